// ----- rtl/core/cda_pkg.sv -----
// ----------------------------------------------------------------------------
// Calendar date arithmetic package
// Shared constants, types and helper functions for the date unit.
// ----------------------------------------------------------------------------
package cda_pkg;

   localparam int MaxYearDefault  = 9999;
   localparam int AddWidthDefault = 16;

   localparam int YearW   = 14;
   localparam int MonthW  = 4;
   localparam int DayW    = 5;
   localparam int DiffW   = 23;
   localparam int NumW    = 24;
   localparam int DaysPerYear = 365;
   localparam int Months      = 12;
   localparam int ShortMonth  = 30;
   localparam int FebDays     = 28;

   typedef enum logic [2:0] {
      CMD_VALIDATE = 3'd0,
      CMD_NEXT     = 3'd1,
      CMD_PREV     = 3'd2,
      CMD_ADD      = 3'd3,
      CMD_DIFF     = 3'd4,
      CMD_CMP      = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_INVALID  = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0]        cmd;
      logic              bad;
      logic [YearW-1:0]  year_a;
      logic [MonthW-1:0] month_a;
      logic [DayW-1:0]   day_a;
      logic [YearW-1:0]  year_b;
      logic [MonthW-1:0] month_b;
      logic [DayW-1:0]   day_b;
      logic [NumW-1:0]   count;
   } entry_type;

   function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                  input logic [1:0] ylow);
      logic [DayW-1:0] r;
      begin
         r = DayW'(ShortMonth + 1);
         if (m == 4'd2) begin
            r = (ylow == 2'd0) ? DayW'(FebDays + 1) : DayW'(FebDays);
         end else if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11) begin
            r = DayW'(ShortMonth);
         end
         return r;
      end
   endfunction

   function automatic logic [8:0] cum_days(input logic [MonthW-1:0] m);
      logic [8:0] r;
      begin
         case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
         endcase
         return r;
      end
   endfunction

endpackage

// ----- rtl/core/cda_front.sv -----
// ----------------------------------------------------------------------------
// Date unit front end
// Accepts commands, checks the input dates and writes entries to the queue.
// ----------------------------------------------------------------------------
module cda_front #(
   parameter int MAX_YEAR        = cda_pkg::MaxYearDefault,
   parameter int ADD_COUNT_WIDTH = cda_pkg::AddWidthDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [2:0]                    req_cmd,
   input  logic [cda_pkg::YearW-1:0]     req_year_a,
   input  logic [cda_pkg::MonthW-1:0]    req_month_a,
   input  logic [cda_pkg::DayW-1:0]      req_day_a,
   input  logic [cda_pkg::YearW-1:0]     req_year_b,
   input  logic [cda_pkg::MonthW-1:0]    req_month_b,
   input  logic [cda_pkg::DayW-1:0]      req_day_b,
   input  logic [ADD_COUNT_WIDTH-1:0]    req_add_count,
   output logic                          q_valid,
   input  logic                          q_ready,
   output cda_pkg::entry_type            q_entry
);

   localparam int Depth = 2;

   cda_pkg::entry_type mem_ff [Depth];
   logic [0:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       a_ok, b_ok, wr, rd;
   cda_pkg::entry_type ent;

   function automatic logic date_ok(input logic [cda_pkg::YearW-1:0] y,
                                    input logic [cda_pkg::MonthW-1:0] m,
                                    input logic [cda_pkg::DayW-1:0] d);
      begin
         return (y != '0) && (32'(y) <= MAX_YEAR) && (m != '0) && (m <= 4'd12) &&
                (d != '0) && (d <= cda_pkg::month_len(m, y[1:0]));
      end
   endfunction

   assign a_ok = date_ok(req_year_a, req_month_a, req_day_a);
   assign b_ok = date_ok(req_year_b, req_month_b, req_day_b);

   always_comb begin
      ent = '0;
      ent.cmd = req_cmd;
      ent.bad = (req_cmd > 3'd5) || !a_ok || (req_cmd >= 3'd4 && !b_ok);
      ent.year_a = req_year_a;
      ent.month_a = req_month_a;
      ent.day_a = req_day_a;
      ent.year_b = req_year_b;
      ent.month_b = req_month_b;
      ent.day_b = req_day_b;
      ent.count = cda_pkg::NumW'(req_add_count);
   end

   assign req_ready = (cnt_ff != 2'(Depth));
   assign wr = req_valid && req_ready;
   assign q_valid = (cnt_ff != 2'd0);
   assign rd = q_valid && q_ready;
   assign q_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in = cnt_ff + 2'(wr) - 2'(rd);
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wr_ptr_ff] <= ent;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ----- rtl/core/cda_back.sv -----
// ----------------------------------------------------------------------------
// Date unit back end
// Executes one queued command at a time and drives the result strobe.
// ----------------------------------------------------------------------------
module cda_back #(
   parameter int MAX_YEAR = cda_pkg::MaxYearDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   output logic                          q_ready,
   input  cda_pkg::entry_type            q_entry,
   output logic                          idle,
   output logic                          rsp_valid,
   output logic [cda_pkg::YearW-1:0]     rsp_out_year,
   output logic [cda_pkg::MonthW-1:0]    rsp_out_month,
   output logic [cda_pkg::DayW-1:0]      rsp_out_day,
   output logic [cda_pkg::DayW-1:0]      rsp_month_length,
   output logic signed [cda_pkg::DiffW-1:0] rsp_day_difference,
   output logic                          rsp_a_after_b,
   output logic                          rsp_dates_equal,
   output logic [1:0]                    rsp_status
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_EXEC = 5'b00010,
      S_ADD  = 5'b00100,
      S_DN_B = 5'b01000,
      S_DIFF = 5'b10000
   } state_type;

   localparam int YearExtW = 17;

   state_type state_ff, state_in;
   cda_pkg::entry_type e_ff, e_in;
   logic [YearExtW-1:0] ry_ff, ry_in;
   logic [cda_pkg::MonthW-1:0] rm_ff, rm_in;
   logic [cda_pkg::NumW:0] rd_ff, rd_in;
   logic signed [cda_pkg::DiffW:0] dn_ff, dn_in;
   logic valid_ff, valid_in;
   logic [cda_pkg::YearW-1:0] oy_ff, oy_in;
   logic [cda_pkg::MonthW-1:0] om_ff, om_in;
   logic [cda_pkg::DayW-1:0] od_ff, od_in, ol_ff, ol_in;
   logic signed [cda_pkg::DiffW-1:0] odf_ff, odf_in;
   logic oab_ff, oab_in, oeq_ff, oeq_in;
   logic [1:0] ost_ff, ost_in;

   logic [cda_pkg::YearW-1:0] dy;
   logic [cda_pkg::MonthW-1:0] dm;
   logic [cda_pkg::DayW-1:0] dd, ml_cur, ml_a;
   logic [8:0] prior_days;
   logic signed [cda_pkg::DiffW:0] dnum;
   logic [cda_pkg::YearW-1:0] ya_m1;
   logic [cda_pkg::MonthW-1:0] pm;
   logic [cda_pkg::YearW-1:0] py;
   logic eq, gt;

   assign idle = (state_ff == S_IDLE) && !valid_ff;
   assign q_ready = (state_ff == S_IDLE);

   always_comb begin
      dy = (state_ff == S_DN_B) ? e_ff.year_b : e_ff.year_a;
      dm = (state_ff == S_DN_B) ? e_ff.month_b : e_ff.month_a;
      dd = (state_ff == S_DN_B) ? e_ff.day_b : e_ff.day_a;
      prior_days = cda_pkg::cum_days(dm);
      if (dm > 4'd2 && dy[1:0] == 2'd0) begin
         prior_days = prior_days + 9'd1;
      end
      ya_m1 = dy - 1'b1;
      dnum = (cda_pkg::DiffW+1)'(dy) * (cda_pkg::DiffW+1)'(cda_pkg::DaysPerYear)
           + (cda_pkg::DiffW+1)'(ya_m1[cda_pkg::YearW-1:2])
           + (cda_pkg::DiffW+1)'(prior_days) + (cda_pkg::DiffW+1)'(dd);
   end

   assign ml_cur = cda_pkg::month_len(rm_ff, ry_ff[1:0]);
   assign ml_a = cda_pkg::month_len(e_ff.month_a, e_ff.year_a[1:0]);

   always_comb begin
      eq = (e_ff.year_a == e_ff.year_b) && (e_ff.month_a == e_ff.month_b) &&
           (e_ff.day_a == e_ff.day_b);
      gt = (e_ff.year_a > e_ff.year_b) ||
           (e_ff.year_a == e_ff.year_b && e_ff.month_a > e_ff.month_b) ||
           (e_ff.year_a == e_ff.year_b && e_ff.month_a == e_ff.month_b &&
            e_ff.day_a > e_ff.day_b);
      pm = (e_ff.month_a == 4'd1) ? 4'(cda_pkg::Months) : e_ff.month_a - 1'b1;
      py = (e_ff.month_a == 4'd1) ? e_ff.year_a - 1'b1 : e_ff.year_a;
   end

   always_comb begin
      state_in = state_ff;
      e_in = e_ff;
      ry_in = ry_ff;
      rm_in = rm_ff;
      rd_in = rd_ff;
      dn_in = dn_ff;
      valid_in = 1'b0;
      oy_in = '0;
      om_in = '0;
      od_in = '0;
      ol_in = '0;
      odf_in = '0;
      oab_in = 1'b0;
      oeq_in = 1'b0;
      ost_in = cda_pkg::ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               e_in = q_entry;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            if (e_ff.bad) begin
               valid_in = 1'b1;
               ost_in = cda_pkg::ST_INVALID;
            end else begin
               case (e_ff.cmd)
                  cda_pkg::CMD_VALIDATE: begin
                     valid_in = 1'b1;
                     oy_in = e_ff.year_a;
                     om_in = e_ff.month_a;
                     od_in = e_ff.day_a;
                     ol_in = ml_a;
                  end
                  cda_pkg::CMD_NEXT: begin
                     valid_in = 1'b1;
                     oy_in = e_ff.year_a;
                     om_in = e_ff.month_a;
                     od_in = e_ff.day_a + 1'b1;
                     if (e_ff.day_a == ml_a) begin
                        od_in = 5'd1;
                        if (e_ff.month_a == 4'(cda_pkg::Months)) begin
                           om_in = 4'd1;
                           if (32'(e_ff.year_a) >= MAX_YEAR) begin
                              oy_in = '0;
                              om_in = '0;
                              od_in = '0;
                              ost_in = cda_pkg::ST_OVERFLOW;
                           end else begin
                              oy_in = e_ff.year_a + 1'b1;
                           end
                        end else begin
                           om_in = e_ff.month_a + 1'b1;
                        end
                     end
                  end
                  cda_pkg::CMD_PREV: begin
                     valid_in = 1'b1;
                     oy_in = e_ff.year_a;
                     om_in = e_ff.month_a;
                     od_in = e_ff.day_a - 1'b1;
                     if (e_ff.day_a == 5'd1) begin
                        if (py == '0) begin
                           oy_in = '0;
                           om_in = '0;
                           od_in = '0;
                           ost_in = cda_pkg::ST_OVERFLOW;
                        end else begin
                           oy_in = py;
                           om_in = pm;
                           od_in = cda_pkg::month_len(pm, py[1:0]);
                        end
                     end
                  end
                  cda_pkg::CMD_ADD: begin
                     ry_in = YearExtW'(e_ff.year_a);
                     rm_in = e_ff.month_a;
                     rd_in = (cda_pkg::NumW+1)'(e_ff.day_a) + (cda_pkg::NumW+1)'(e_ff.count);
                     state_in = S_ADD;
                  end
                  cda_pkg::CMD_DIFF: begin
                     dn_in = dnum;
                     state_in = S_DN_B;
                  end
                  cda_pkg::CMD_CMP: begin
                     valid_in = 1'b1;
                     oab_in = gt;
                     oeq_in = eq;
                  end
                  default: begin
                     valid_in = 1'b1;
                     ost_in = cda_pkg::ST_INVALID;
                  end
               endcase
            end
         end
         S_ADD: begin
            if (rd_ff > (cda_pkg::NumW+1)'(ml_cur)) begin
               rd_in = rd_ff - (cda_pkg::NumW+1)'(ml_cur);
               if (rm_ff == 4'(cda_pkg::Months)) begin
                  rm_in = 4'd1;
                  ry_in = ry_ff + 1'b1;
                  if (32'(ry_ff) >= MAX_YEAR) begin
                     valid_in = 1'b1;
                     ost_in = cda_pkg::ST_OVERFLOW;
                     state_in = S_IDLE;
                  end
               end else begin
                  rm_in = rm_ff + 1'b1;
               end
            end else begin
               valid_in = 1'b1;
               oy_in = ry_ff[cda_pkg::YearW-1:0];
               om_in = rm_ff;
               od_in = rd_ff[cda_pkg::DayW-1:0];
               state_in = S_IDLE;
            end
         end
         S_DN_B: begin
            dn_in = dn_ff - dnum;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            valid_in = 1'b1;
            odf_in = dn_ff[cda_pkg::DiffW-1:0];
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      e_ff <= e_in;
      ry_ff <= ry_in;
      rm_ff <= rm_in;
      rd_ff <= rd_in;
      dn_ff <= dn_in;
      oy_ff <= oy_in;
      om_ff <= om_in;
      od_ff <= od_in;
      ol_ff <= ol_in;
      odf_ff <= odf_in;
      oab_ff <= oab_in;
      oeq_ff <= oeq_in;
      ost_ff <= ost_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_out_year = oy_ff;
   assign rsp_out_month = om_ff;
   assign rsp_out_day = od_ff;
   assign rsp_month_length = ol_ff;
   assign rsp_day_difference = odf_ff;
   assign rsp_a_after_b = oab_ff;
   assign rsp_dates_equal = oeq_ff;
   assign rsp_status = ost_ff;

endmodule

// ----- rtl/core/calendar_date_arithmetic_core.sv -----
// ----------------------------------------------------------------------------
// A transfer enters the queue; the back end takes it when idle, executes it and
// registers the result. Difference also passes the DN_B and DIFF states; add steps
// one month at a time in the month step loop (up to about 2160 months for a count
// of 65535). The back end takes no new command until the last is done; a two-entry
// queue takes commands ahead. Reset is synchronous and empties the queue; the
// receiver cannot stall.
// ----------------------------------------------------------------------------
// Calendar date arithmetic core
// Julian-rule date unit: validate, next, previous, add, difference, compare.
// ----------------------------------------------------------------------------
module calendar_date_arithmetic_core #(
   parameter int MAX_YEAR        = cda_pkg::MaxYearDefault,
   parameter int ADD_COUNT_WIDTH = cda_pkg::AddWidthDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [2:0]                    req_cmd,
   input  logic [cda_pkg::YearW-1:0]     req_year_a,
   input  logic [cda_pkg::MonthW-1:0]    req_month_a,
   input  logic [cda_pkg::DayW-1:0]      req_day_a,
   input  logic [cda_pkg::YearW-1:0]     req_year_b,
   input  logic [cda_pkg::MonthW-1:0]    req_month_b,
   input  logic [cda_pkg::DayW-1:0]      req_day_b,
   input  logic [ADD_COUNT_WIDTH-1:0]    req_add_count,
   output logic                          rsp_valid,
   output logic [cda_pkg::YearW-1:0]     rsp_out_year,
   output logic [cda_pkg::MonthW-1:0]    rsp_out_month,
   output logic [cda_pkg::DayW-1:0]      rsp_out_day,
   output logic [cda_pkg::DayW-1:0]      rsp_month_length,
   output logic signed [cda_pkg::DiffW-1:0] rsp_day_difference,
   output logic                          rsp_a_after_b,
   output logic                          rsp_dates_equal,
   output logic [1:0]                    rsp_status
);

   logic req_ready, q_valid, q_ready, back_idle;
   cda_pkg::entry_type q_entry;

   assign busy = !req_ready || !back_idle && 1'b0;

   cda_front #(
      .MAX_YEAR(MAX_YEAR),
      .ADD_COUNT_WIDTH(ADD_COUNT_WIDTH)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(start),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_year_a(req_year_a),
      .req_month_a(req_month_a),
      .req_day_a(req_day_a),
      .req_year_b(req_year_b),
      .req_month_b(req_month_b),
      .req_day_b(req_day_b),
      .req_add_count(req_add_count),
      .q_valid(q_valid),
      .q_ready(q_ready),
      .q_entry(q_entry)
   );

   cda_back #(
      .MAX_YEAR(MAX_YEAR)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .q_valid(q_valid),
      .q_ready(q_ready),
      .q_entry(q_entry),
      .idle(back_idle),
      .rsp_valid(rsp_valid),
      .rsp_out_year(rsp_out_year),
      .rsp_out_month(rsp_out_month),
      .rsp_out_day(rsp_out_day),
      .rsp_month_length(rsp_month_length),
      .rsp_day_difference(rsp_day_difference),
      .rsp_a_after_b(rsp_a_after_b),
      .rsp_dates_equal(rsp_dates_equal),
      .rsp_status(rsp_status)
   );

endmodule

// ----- tb/calendar_date_arithmetic_checker.sv -----
// ----------------------------------------------------------------------------
// Calendar date arithmetic checker
// Watches the command and result channels of the date unit. For every command
// transfer it computes the expected result and queues it. Each result strobe is
// compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module calendar_date_arithmetic_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  logic [2:0]                       req_cmd,
   input  logic [cda_pkg::YearW-1:0]        req_year_a,
   input  logic [cda_pkg::MonthW-1:0]       req_month_a,
   input  logic [cda_pkg::DayW-1:0]         req_day_a,
   input  logic [cda_pkg::YearW-1:0]        req_year_b,
   input  logic [cda_pkg::MonthW-1:0]       req_month_b,
   input  logic [cda_pkg::DayW-1:0]         req_day_b,
   input  logic [15:0]                      req_add_count,
   input  logic                             rsp_valid,
   input  logic [cda_pkg::YearW-1:0]        rsp_out_year,
   input  logic [cda_pkg::MonthW-1:0]       rsp_out_month,
   input  logic [cda_pkg::DayW-1:0]         rsp_out_day,
   input  logic [cda_pkg::DayW-1:0]         rsp_month_length,
   input  logic signed [cda_pkg::DiffW-1:0] rsp_day_difference,
   input  logic                             rsp_a_after_b,
   input  logic                             rsp_dates_equal,
   input  logic [1:0]                       rsp_status,
   output int                               errors,
   output int                               pending
);

   localparam int LastYear = 9999;

   typedef struct {
      logic [cda_pkg::YearW-1:0]  year;
      logic [cda_pkg::MonthW-1:0] month;
      logic [cda_pkg::DayW-1:0]   day;
      logic [cda_pkg::DayW-1:0]   mlen;
      logic [cda_pkg::DiffW-1:0]  diff;
      logic                       after;
      logic                       equal;
      cda_pkg::status_type        status;
   } date_result_type;

   date_result_type expected_dates[$];

   function automatic int month_days(int m, int y);
      if (m == 2) return (y % 4 == 0) ? 29 : 28;
      if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
      return 31;
   endfunction

   function automatic bit date_valid(int y, int m, int d);
      if (y < 1 || y > LastYear || m < 1 || m > 12) return 0;
      return d >= 1 && d <= month_days(m, y);
   endfunction

   function automatic longint serial_day(int y, int m, int d);
      longint n;
      n = longint'(y) * 365 + (y - 1) / 4 + d;
      for (int k = 1; k < m; k++) n += month_days(k, y);
      return n;
   endfunction

   function automatic date_result_type compute_date(int c, int ya, int ma, int da,
                                                    int yb, int mb, int db, int n);
      date_result_type r;
      int ry, rm, rd;
      bit date_out;
      r = '{default: 0, status: cda_pkg::ST_OK};
      ry = ya; rm = ma; rd = da;
      date_out = 0;
      if (c > 5 || !date_valid(ya, ma, da) || (c >= 4 && !date_valid(yb, mb, db))) begin
         r.status = cda_pkg::ST_INVALID;
      end else begin
         case (cda_pkg::cmd_type'(c))
            cda_pkg::CMD_VALIDATE: begin
               date_out = 1;
               r.mlen = cda_pkg::DayW'(month_days(ma, ya));
            end
            cda_pkg::CMD_NEXT: begin
               rd = da + 1;
               if (rd > month_days(rm, ry)) begin
                  rd = 1;
                  rm++;
                  if (rm > 12) begin
                     rm = 1;
                     ry++;
                  end
               end
               if (ry > LastYear) r.status = cda_pkg::ST_OVERFLOW;
               else date_out = 1;
            end
            cda_pkg::CMD_PREV: begin
               rd = da - 1;
               if (rd < 1) begin
                  rm--;
                  if (rm < 1) begin
                     rm = 12;
                     ry--;
                  end
                  rd = month_days(rm, ry);
               end
               if (ry < 1) r.status = cda_pkg::ST_OVERFLOW;
               else date_out = 1;
            end
            cda_pkg::CMD_ADD: begin
               rd = da + n;
               while (rd > month_days(rm, ry) && r.status == cda_pkg::ST_OK) begin
                  rd -= month_days(rm, ry);
                  rm++;
                  if (rm > 12) begin
                     rm = 1;
                     ry++;
                     if (ry > LastYear) r.status = cda_pkg::ST_OVERFLOW;
                  end
               end
               date_out = (r.status == cda_pkg::ST_OK);
            end
            cda_pkg::CMD_DIFF: begin
               r.diff = cda_pkg::DiffW'(serial_day(ya, ma, da) - serial_day(yb, mb, db));
            end
            default: begin
               r.equal = (ya == yb && ma == mb && da == db);
               r.after = ya > yb || (ya == yb && (ma > mb || (ma == mb && da > db)));
            end
         endcase
      end
      if (date_out) begin
         r.year = cda_pkg::YearW'(ry);
         r.month = cda_pkg::MonthW'(rm);
         r.day = cda_pkg::DayW'(rd);
      end
      return r;
   endfunction

   assign pending = expected_dates.size();

   always @(posedge clock) begin
      date_result_type e;
      if (reset) begin
         expected_dates.delete();
         errors <= errors;
      end else begin
         if (start && !busy) begin
            expected_dates.push_back(compute_date(int'(req_cmd), int'(req_year_a),
               int'(req_month_a), int'(req_day_a), int'(req_year_b), int'(req_month_b),
               int'(req_day_b), int'(req_add_count)));
         end
         if (rsp_valid) begin
            if (expected_dates.size() == 0) begin
               $error("result transfer with no command outstanding");
               errors <= errors + 1;
            end else begin
               e = expected_dates.pop_front();
               if (rsp_out_year !== e.year || rsp_out_month !== e.month ||
                   rsp_out_day !== e.day || rsp_month_length !== e.mlen ||
                   rsp_day_difference !== e.diff || rsp_a_after_b !== e.after ||
                   rsp_dates_equal !== e.equal || rsp_status !== e.status) begin
                  errors <= errors + 1;
                  if (rsp_out_year !== e.year)
                     $error("out_year expected %0d actual %0d", e.year, rsp_out_year);
                  if (rsp_out_month !== e.month)
                     $error("out_month expected %0d actual %0d", e.month, rsp_out_month);
                  if (rsp_out_day !== e.day)
                     $error("out_day expected %0d actual %0d", e.day, rsp_out_day);
                  if (rsp_month_length !== e.mlen)
                     $error("month_length expected %0d actual %0d", e.mlen,
                            rsp_month_length);
                  if (rsp_day_difference !== e.diff)
                     $error("day_difference expected %0d actual %0d", $signed(e.diff),
                            rsp_day_difference);
                  if (rsp_a_after_b !== e.after)
                     $error("a_after_b expected %0d actual %0d", e.after, rsp_a_after_b);
                  if (rsp_dates_equal !== e.equal)
                     $error("dates_equal expected %0d actual %0d", e.equal, rsp_dates_equal);
                  if (rsp_status !== e.status)
                     $error("status expected %0d actual %0d", e.status, rsp_status);
               end
            end
         end
      end
   end

   initial errors = 0;

endmodule

// ----- tb/calendar_date_arithmetic_core_test.sv -----
// ----------------------------------------------------------------------------
// Calendar date arithmetic core test
// Drives directed corner cases and then random commands into the date unit,
// with random gaps between some random transfers. The checker beside the unit
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module calendar_date_arithmetic_core_test;

   localparam int StallLimit = 30000;

   logic clock = 0;
   logic reset;
   logic start;
   logic busy;
   logic [2:0] req_cmd;
   logic [cda_pkg::YearW-1:0] req_year_a, req_year_b;
   logic [cda_pkg::MonthW-1:0] req_month_a, req_month_b;
   logic [cda_pkg::DayW-1:0] req_day_a, req_day_b;
   logic [15:0] req_add_count;
   logic rsp_valid;
   logic [cda_pkg::YearW-1:0] rsp_out_year;
   logic [cda_pkg::MonthW-1:0] rsp_out_month;
   logic [cda_pkg::DayW-1:0] rsp_out_day, rsp_month_length;
   logic signed [cda_pkg::DiffW-1:0] rsp_day_difference;
   logic rsp_a_after_b, rsp_dates_equal;
   logic [1:0] rsp_status;
   int errors, pending, quiet_cycles;
   int cmd_seen[8];

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   calendar_date_arithmetic_core dut (.*);
   calendar_date_arithmetic_checker u_checker (.*);

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic issue(int c, int ya, int ma, int da, int yb, int mb, int db, int n,
                        bit allow_gap);
      req_cmd <= 3'(c);
      req_year_a <= cda_pkg::YearW'(ya);
      req_month_a <= cda_pkg::MonthW'(ma);
      req_day_a <= cda_pkg::DayW'(da);
      req_year_b <= cda_pkg::YearW'(yb);
      req_month_b <= cda_pkg::MonthW'(mb);
      req_day_b <= cda_pkg::DayW'(db);
      req_add_count <= 16'(n);
      start <= 1;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      cmd_seen[c]++;
      if (allow_gap && $urandom_range(99) < 7) begin
         start <= 0;
         @(posedge clock);
      end
   endtask

   task automatic random_date(output int y, output int m, output int d);
      case ($urandom_range(9))
         0: y = $urandom_range(1, 4);
         1: y = $urandom_range(9996, 9999);
         default: y = $urandom_range(1, 9999);
      endcase
      m = $urandom_range(1, 12);
      d = (m == 2) ? ((y % 4 == 0) ? 29 : 28)
                   : ((m == 4 || m == 6 || m == 9 || m == 11) ? 30 : 31);
      if ($urandom_range(3) != 0) d = $urandom_range(1, d);
   endtask

   initial begin
      int ya, ma, da, yb, mb, db, n, c;
      reset <= 1;
      start <= 0;
      req_cmd <= cda_pkg::CMD_VALIDATE;
      req_year_a <= 0;
      req_month_a <= 0;
      req_day_a <= 0;
      req_year_b <= 0;
      req_month_b <= 0;
      req_day_b <= 0;
      req_add_count <= 0;
      quiet_cycles <= 0;
      repeat (8) @(posedge clock);
      reset <= 0;

      issue(cda_pkg::CMD_VALIDATE, 4, 2, 29, 0, 0, 0, 0, 0);
      issue(cda_pkg::CMD_VALIDATE, 5, 2, 29, 0, 0, 0, 0, 0);
      issue(cda_pkg::CMD_VALIDATE, 0, 1, 1, 0, 0, 0, 0, 0);
      issue(cda_pkg::CMD_VALIDATE, 16383, 15, 31, 0, 0, 0, 0, 0);
      issue(cda_pkg::CMD_VALIDATE, 10000, 0, 0, 0, 0, 0, 0, 0);
      issue(cda_pkg::CMD_VALIDATE, 2001, 13, 1, 0, 0, 0, 0, 0);
      issue(cda_pkg::CMD_VALIDATE, 2001, 4, 31, 0, 0, 0, 0, 0);
      issue(cda_pkg::CMD_NEXT, 9999, 12, 31, 0, 0, 0, 0, 0);
      issue(cda_pkg::CMD_NEXT, 8, 2, 28, 0, 0, 0, 0, 0);
      issue(cda_pkg::CMD_NEXT, 1999, 12, 31, 0, 0, 0, 0, 0);
      issue(cda_pkg::CMD_PREV, 1, 1, 1, 0, 0, 0, 0, 0);
      issue(cda_pkg::CMD_PREV, 12, 3, 1, 0, 0, 0, 0, 0);
      issue(cda_pkg::CMD_PREV, 13, 3, 1, 0, 0, 0, 0, 0);
      issue(cda_pkg::CMD_ADD, 500, 7, 15, 0, 0, 0, 0, 0);
      issue(cda_pkg::CMD_ADD, 1, 1, 1, 0, 0, 0, 65535, 0);
      issue(cda_pkg::CMD_ADD, 9990, 1, 1, 0, 0, 0, 65535, 0);
      issue(cda_pkg::CMD_ADD, 9999, 12, 31, 0, 0, 0, 1, 0);
      issue(cda_pkg::CMD_DIFF, 9999, 12, 31, 1, 1, 1, 0, 0);
      issue(cda_pkg::CMD_DIFF, 1, 1, 1, 9999, 12, 31, 0, 0);
      issue(cda_pkg::CMD_DIFF, 4, 3, 1, 4, 2, 29, 0, 0);
      issue(cda_pkg::CMD_DIFF, 4, 3, 1, 4, 2, 30, 0, 0);
      issue(cda_pkg::CMD_CMP, 2020, 5, 5, 2020, 5, 5, 0, 0);
      issue(cda_pkg::CMD_CMP, 2020, 5, 6, 2020, 5, 5, 0, 0);
      issue(6, 2020, 5, 5, 2020, 5, 5, 0, 0);
      issue(7, 2020, 5, 5, 2020, 5, 5, 0, 0);

      for (int i = 0; i < 245; i++) begin
         random_date(ya, ma, da);
         random_date(yb, mb, db);
         c = $urandom_range(5);
         n = ($urandom_range(19) == 0) ? $urandom_range(65535) : $urandom_range(400);
         if ($urandom_range(9) == 0) begin
            c = $urandom_range(7);
            ya = $urandom_range(16383);
            ma = $urandom_range(15);
            da = $urandom_range(31);
            yb = $urandom_range(16383);
            mb = $urandom_range(15);
            db = $urandom_range(31);
         end
         if (c == cda_pkg::CMD_CMP && $urandom_range(3) == 0) begin
            yb = ya;
            mb = ma;
            if ($urandom_range(1)) db = da;
         end
         issue(c, ya, ma, da, yb, mb, db, n, i < 100 || i >= 180);
      end
      start <= 0;

      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Covered %0d validate, %0d next, %0d previous, %0d add, %0d difference,",
               cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3], cmd_seen[4]);
      $display("%0d compare and %0d unused-code commands.", cmd_seen[5],
               cmd_seen[6] + cmd_seen[7]);
      if (errors == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
